// ===== sv/smd_pkg.sv =====
// slider message decoder: shared types, constants and helper functions
// no dependencies; imported by the arithmetic unit and the top level
`timescale 1ns / 1ps
`default_nettype none

package smd_pkg;

  // ring geometry
  localparam int RING_DEPTH = 19;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int IDX_W      = RING_AW + 1;
  localparam int SCAN_W     = $clog2(RING_DEPTH + 1);
  localparam int BYTE_W     = 8;

  // field widths
  localparam int NIB_W    = 4;
  localparam int VALUE_W  = 8;
  localparam int SLIDER_W = 7;
  localparam int GAIN_W   = 15;
  localparam int ECHO_W   = 14;

  // message layout, relative to the start marker
  localparam logic [IDX_W-1:0] ID_OFFSET = IDX_W'(10);
  localparam logic [IDX_W-1:0] HI_OFFSET = IDX_W'(12);
  localparam logic [IDX_W-1:0] LO_OFFSET = IDX_W'(13);

  // characters
  localparam logic [BYTE_W-1:0] CHAR_N     = 8'h4E;
  localparam logic [BYTE_W-1:0] CHAR_A     = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_C     = 8'h43;
  localparam logic [BYTE_W-1:0] CHAR_E     = 8'h45;
  localparam logic [BYTE_W-1:0] CHAR_F     = 8'h46;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_TWO   = 8'h32;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  // scaling
  localparam int SLIDER_MAX = 100;
  localparam int FULL_SCALE = 32767;
  localparam int BAND_STEP  = FULL_SCALE / SLIDER_MAX;
  localparam int ECHO_STEP  = FULL_SCALE / 200;

  // clip level: (100 - v) * 32767 / 100 as a multiply by the rounded-up
  // reciprocal scaled by 2^16, exact for every slider step from 0 to 100
  localparam int CLIP_SHIFT = 16;
  localparam int CLIP_RECIP = (FULL_SCALE * (1 << CLIP_SHIFT) + SLIDER_MAX - 1) / SLIDER_MAX;

  // reset values of the settings
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(16350);
  localparam logic [GAIN_W-1:0] CLIP_RESET = GAIN_W'(FULL_SCALE);
  localparam logic [ECHO_W-1:0] ECHO_RESET = '0;

  // shared arithmetic unit
  localparam int ARITH_W   = 32;
  localparam int MUL_STEPS = SLIDER_W;
  localparam int CNT_W     = $clog2(MUL_STEPS);

  typedef enum logic [2:0] {
    CODE_BASS    = 3'd0,
    CODE_MID     = 3'd1,
    CODE_HIGH    = 3'd2,
    CODE_DIST    = 3'd3,
    CODE_REVERB  = 3'd4,
    CODE_UNKNOWN = 3'd5
  } smd_code_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD_ID,
    ST_RD_HI,
    ST_RD_LO,
    ST_DECODE,
    ST_MUL,
    ST_COMMIT
  } smd_state_e;

  typedef struct packed {
    logic                start;
    logic [ARITH_W-1:0]  b;
    logic [SLIDER_W-1:0] m;
  } smd_arith_cmd_t;

  typedef struct packed {
    logic                done;
    logic [ARITH_W-1:0]  result;
  } smd_arith_sts_t;

  // hex character to nibble, anything else reads as zero
  function automatic logic [NIB_W-1:0] hex_digit(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] t;
    t = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      t = c - CHAR_ZERO;
    end else if (c >= CHAR_A && c <= CHAR_F) begin
      t = c - CHAR_A + BYTE_W'(10);
    end
    return t[NIB_W-1:0];
  endfunction

  // ring index with a single wrap
  function automatic logic [RING_AW-1:0] ring_wrap(input logic [RING_AW-1:0] base,
                                                   input logic [IDX_W-1:0]   off);
    logic [IDX_W-1:0] sum;
    sum = {1'b0, base} + off;
    if (sum > IDX_W'(RING_DEPTH - 1)) begin
      sum = sum - IDX_W'(RING_DEPTH);
    end
    return sum[RING_AW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/smd_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module smd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/smd_arith.sv =====
// shared iterative arithmetic unit: shift-add multiply of a constant by the slider
// depends on smd_pkg (command and status structs, step counts)
`timescale 1ns / 1ps
`default_nettype none

module smd_arith (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  smd_pkg::smd_arith_cmd_t cmd_i,
  output smd_pkg::smd_arith_sts_t sts_o
);

  import smd_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [ARITH_W-1:0]  a_q, a_d;
  logic [ARITH_W-1:0]  b_q, b_d;
  logic [SLIDER_W-1:0] m_q, m_d;

  logic [ARITH_W-1:0]  addend;

  // one adder: accumulate the shifted constant for each set multiplier bit
  always_comb begin
    addend = m_q[0] ? b_q : '0;
    a_d    = a_q + addend;
    m_d    = m_q >> 1;
    b_d    = b_q << 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(MUL_STEPS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      a_q <= '0;
      b_q <= cmd_i.b;
      m_q <= cmd_i.m;
    end else if (busy_q) begin
      a_q <= a_d;
      b_q <= b_d;
      m_q <= m_d;
    end
  end

  assign sts_o.done   = done_q;
  assign sts_o.result = a_q;

endmodule

`default_nettype wire

// ===== sv/slider_message_decoder_top.sv =====
// slider message decoder top level: receive ring, scan sequencer, settings
// depends on smd_pkg, smd_ram and smd_arith
//
// usage
//   input channel: one received byte per transfer on rx_byte_i (in_valid_i /
//   in_ready_o). output channel: one result per input byte (out_valid_o /
//   out_ready_i) carrying update_found, setting_code, slider_value and the
//   current five settings after this byte's update.
// sequence
//   each byte is written into the ring in its accept cycle, then the ring is
//   scanned from slot 0, one slot per cycle through the ram read port, for
//   the first start marker, or to its end if there is none. after a marker
//   the id and slider digits are read; an unrecognised id goes to commit, and
//   any recognised setting runs a 7-step shift-add multiply (the clip level
//   multiplies 100 - v by a scaled reciprocal of 100 and keeps the top bits).
//   the ram read port and the multiplier are single and shared; one byte is
//   in work at a time, in_ready_o is high only while the sequencer is idle,
//   so the next byte can go in the cycle after the result is registered.
// reset
//   the ring reads as all zero (per-slot valid bits), write slot 0, band
//   gains 16350, clip level 32767, reverb gain 0, no result pending.
// stalls
//   a finished result sits in the output register; the next byte is still
//   taken, and its result waits in the commit state until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module slider_message_decoder_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [smd_pkg::BYTE_W-1:0]  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        update_found_o,
  output logic [2:0]                  setting_code_o,
  output logic [smd_pkg::VALUE_W-1:0] slider_value_o,
  output logic [smd_pkg::GAIN_W-1:0]  bass_gain_o,
  output logic [smd_pkg::GAIN_W-1:0]  mid_gain_o,
  output logic [smd_pkg::GAIN_W-1:0]  high_gain_o,
  output logic [smd_pkg::GAIN_W-1:0]  clip_level_o,
  output logic [smd_pkg::ECHO_W-1:0]  reverb_gain_o
);

  import smd_pkg::*;

  smd_state_e state_q, state_d;

  // ring bookkeeping
  logic [RING_AW-1:0]    ws_q;
  logic [RING_DEPTH-1:0] vld_q;
  logic [RING_AW-1:0]    rd_addr;
  logic [BYTE_W-1:0]     rdata;
  logic                  rd_vld_q;
  logic [BYTE_W-1:0]     rbyte;

  // scan state
  logic [SCAN_W-1:0]  scan_q;
  logic [RING_AW-1:0] chk_q;
  logic               chk_vld_q;
  logic               issue;
  logic               match;
  logic               scan_last;
  logic [RING_AW-1:0] marker_q;

  // fields of the message being decoded
  logic [BYTE_W-1:0]  id_q;
  logic [NIB_W-1:0]   hi_q;
  logic [VALUE_W-1:0] value_q;
  smd_code_e          code_q;
  logic               found_q;

  logic [VALUE_W-1:0]  dec_value;
  logic [SLIDER_W-1:0] dec_sat;
  smd_code_e           dec_code;

  // settings
  logic [GAIN_W-1:0] bass_q, mid_q, treble_q, clip_q;
  logic [ECHO_W-1:0] echo_q;

  // output register
  logic               out_valid_q;
  logic               out_found_q;
  smd_code_e          out_code_q;
  logic [VALUE_W-1:0] out_value_q;
  logic [GAIN_W-1:0]  out_bass_q, out_mid_q, out_high_q, out_clip_q;
  logic [ECHO_W-1:0]  out_echo_q;

  logic in_accept;
  logic out_free;
  logic commit_fire;

  smd_arith_cmd_t arith_cmd;
  smd_arith_sts_t arith_sts;

  // receive ring
  smd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (ws_q),
    .wdata_i (rx_byte_i),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // shared multiply unit
  smd_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (arith_cmd),
    .sts_o  (arith_sts)
  );

  // slots never written since reset read as zero
  assign rbyte = rd_vld_q ? rdata : '0;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i & in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign commit_fire = (state_q == ST_COMMIT) && out_free;

  // scan: read slot scan_q while checking the byte read for slot chk_q
  assign issue     = (state_q == ST_SCAN) && (scan_q != SCAN_W'(RING_DEPTH));
  assign match     = chk_vld_q && (rbyte == CHAR_N);
  assign scan_last = chk_vld_q && (chk_q == RING_AW'(RING_DEPTH - 1));

  // decode of id, slider digits and saturation
  always_comb begin
    dec_value = {hi_q, hex_digit(rbyte)};
    dec_sat   = (dec_value > VALUE_W'(SLIDER_MAX)) ? SLIDER_W'(SLIDER_MAX)
                                                   : dec_value[SLIDER_W-1:0];
    unique case (id_q)
      CHAR_A:    dec_code = CODE_BASS;
      CHAR_C:    dec_code = CODE_MID;
      CHAR_E:    dec_code = CODE_HIGH;
      CHAR_ZERO: dec_code = CODE_DIST;
      CHAR_TWO:  dec_code = CODE_REVERB;
      default:   dec_code = CODE_UNKNOWN;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match) begin
          state_d = ST_RD_ID;
        end else if (scan_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_RD_ID:  state_d = ST_RD_HI;
      ST_RD_HI:  state_d = ST_RD_LO;
      ST_RD_LO:  state_d = ST_DECODE;
      ST_DECODE: begin
        state_d = (dec_code == CODE_UNKNOWN) ? ST_COMMIT : ST_MUL;
      end
      ST_MUL: begin
        if (arith_sts.done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: ring read address and multiply command
  always_comb begin
    rd_addr         = '0;
    arith_cmd.start = 1'b0;
    arith_cmd.b     = '0;
    arith_cmd.m     = '0;
    unique case (state_q)
      ST_SCAN: begin
        if (issue) begin
          rd_addr = scan_q[RING_AW-1:0];
        end
      end
      ST_RD_ID: rd_addr = ring_wrap(marker_q, ID_OFFSET);
      ST_RD_HI: rd_addr = ring_wrap(marker_q, HI_OFFSET);
      ST_RD_LO: rd_addr = ring_wrap(marker_q, LO_OFFSET);
      ST_DECODE: begin
        // clip level is (100 - v) times the scaled reciprocal, the rest step * v
        if (dec_code != CODE_UNKNOWN) begin
          arith_cmd.start = 1'b1;
          if (dec_code == CODE_DIST) begin
            arith_cmd.b = ARITH_W'(CLIP_RECIP);
            arith_cmd.m = SLIDER_W'(SLIDER_MAX) - dec_sat;
          end else if (dec_code == CODE_REVERB) begin
            arith_cmd.b = ARITH_W'(ECHO_STEP);
            arith_cmd.m = dec_sat;
          end else begin
            arith_cmd.b = ARITH_W'(BAND_STEP);
            arith_cmd.m = dec_sat;
          end
        end
      end
      default: ;
    endcase
  end

  // control state, settings and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ws_q        <= '0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      scan_q      <= '0;
      chk_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      code_q      <= CODE_BASS;
      bass_q      <= GAIN_RESET;
      mid_q       <= GAIN_RESET;
      treble_q    <= GAIN_RESET;
      clip_q      <= CLIP_RESET;
      echo_q      <= ECHO_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= vld_q[rd_addr];

      if (in_accept) begin
        vld_q[ws_q] <= 1'b1;
        ws_q        <= (ws_q == RING_AW'(RING_DEPTH - 1)) ? '0 : ws_q + 1'b1;
        scan_q      <= '0;
        chk_vld_q   <= 1'b0;
        found_q     <= 1'b0;
        code_q      <= CODE_BASS;
      end

      if (state_q == ST_SCAN) begin
        chk_vld_q <= issue;
        if (issue) begin
          scan_q <= scan_q + 1'b1;
        end
        if (match) begin
          found_q <= 1'b1;
        end
      end

      if (state_q == ST_DECODE) begin
        code_q <= dec_code;
      end

      // write back the finished setting
      if (state_q == ST_MUL && arith_sts.done) begin
        case (code_q)
          CODE_BASS:   bass_q   <= arith_sts.result[GAIN_W-1:0];
          CODE_MID:    mid_q    <= arith_sts.result[GAIN_W-1:0];
          CODE_HIGH:   treble_q <= arith_sts.result[GAIN_W-1:0];
          CODE_DIST:   clip_q   <= arith_sts.result[CLIP_SHIFT +: GAIN_W];
          CODE_REVERB: echo_q   <= arith_sts.result[ECHO_W-1:0];
          default: ;
        endcase
      end

      if (commit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      value_q <= '0;
    end
    if (state_q == ST_SCAN) begin
      chk_q <= scan_q[RING_AW-1:0];
      if (match) begin
        marker_q <= chk_q;
      end
    end
    if (state_q == ST_RD_HI) begin
      id_q <= rbyte;
    end
    if (state_q == ST_RD_LO) begin
      hi_q <= hex_digit(rbyte);
    end
    if (state_q == ST_DECODE) begin
      value_q <= dec_value;
    end
    if (commit_fire) begin
      out_found_q <= found_q;
      out_code_q  <= code_q;
      out_value_q <= value_q;
      out_bass_q  <= bass_q;
      out_mid_q   <= mid_q;
      out_high_q  <= treble_q;
      out_clip_q  <= clip_q;
      out_echo_q  <= echo_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign update_found_o = out_found_q;
  assign setting_code_o = out_code_q;
  assign slider_value_o = out_value_q;
  assign bass_gain_o    = out_bass_q;
  assign mid_gain_o     = out_mid_q;
  assign high_gain_o    = out_high_q;
  assign clip_level_o   = out_clip_q;
  assign reverb_gain_o  = out_echo_q;

endmodule

`default_nettype wire
